### src/assert_macros.svh
// Assertion macros shared by the rational arithmetic unit modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/rau_pkg.sv
// Package for the rational arithmetic unit: widths, codes and shared types.
// No dependencies.
package rau_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MagWidth   = 64;
  localparam int unsigned CntWidth   = 6;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_NEG = 3'd4,
    FUNC_EQ  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // item after classification by the front end
  typedef struct packed {
    logic [2:0]            func;
    logic                  early;
    logic [1:0]            status;
    logic                  a_neg;
    logic [ValueWidth-1:0] a_mag;
    logic [ValueWidth-1:0] a_den;
    logic                  b_neg;
    logic [ValueWidth-1:0] b_mag;
    logic [ValueWidth-1:0] b_den;
  } item_t;

  typedef struct packed {
    logic [31:0] result_numerator;
    logic [30:0] result_denominator;
    logic        is_equal;
    logic [1:0]  status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_RED_R,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    G_IDLE,
    G_MOD,
    G_DONE
  } gcd_state_e;

  typedef enum logic [1:0] {
    PH_EUCLID,
    PH_MAG,
    PH_DEN
  } gcd_phase_e;

endpackage

### src/rau_if.sv
// Valid/ready channel interfaces for the rational arithmetic unit.
// No dependencies.
interface rau_in_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   func;
  logic signed [31:0]           left_numerator;
  logic signed [31:0]           left_denominator;
  logic signed [31:0]           right_numerator;
  logic signed [31:0]           right_denominator;
  modport source (output valid, func, left_numerator, left_denominator, right_numerator,
                  right_denominator, input ready);
  modport sink (input valid, func, left_numerator, left_denominator, right_numerator,
                right_denominator, output ready);
endinterface

interface rau_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  result_numerator;
  logic [30:0]         result_denominator;
  logic                is_equal;
  logic [1:0]          status;
  modport source (output valid, result_numerator, result_denominator, is_equal, status,
                  input ready);
  modport sink (input valid, result_numerator, result_denominator, is_equal, status,
                output ready);
endinterface

### src/rau_front.sv
// Front end: accept a transaction, split operands into sign and magnitude, flag errors.
// Queues up to two items for the back end. Depends on rau_pkg.
module rau_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      func_i,
  input  logic [31:0]     ln_i,
  input  logic [31:0]     ld_i,
  input  logic [31:0]     rn_i,
  input  logic [31:0]     rd_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output rau_pkg::item_t  q_item_o
);
  import rau_pkg::*;

  logic  [QueueDepth-1:0] vld_q, vld_d;
  item_t                  ent_q [QueueDepth];
  logic                   wr_ptr_q, rd_ptr_q;
  item_t                  cls;
  logic                   push, pop;
  logic                   ln_s, ld_s, rn_s, rd_s;
  logic [ValueWidth-1:0]  ln_m, ld_m, rn_m, rd_m;

  function automatic logic [ValueWidth-1:0] absv(input logic [ValueWidth-1:0] v);
    absv = v[ValueWidth-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    ln_s = ln_i[ValueWidth-1];
    ld_s = ld_i[ValueWidth-1];
    rn_s = rn_i[ValueWidth-1];
    rd_s = rd_i[ValueWidth-1];
    ln_m = absv(ln_i[ValueWidth-1:0]);
    ld_m = absv(ld_i[ValueWidth-1:0]);
    rn_m = absv(rn_i[ValueWidth-1:0]);
    rd_m = absv(rd_i[ValueWidth-1:0]);
    cls        = '0;
    cls.func   = func_i;
    cls.a_neg  = ln_s ^ ld_s;
    cls.a_mag  = ln_m;
    cls.a_den  = ld_m;
    cls.b_neg  = rn_s ^ rd_s;
    cls.b_mag  = rn_m;
    cls.b_den  = rd_m;
    if (func_i > FUNC_EQ) begin
      cls.early  = 1'b1;
      cls.status = ST_OK;
    end else if (ld_m == '0 || (func_i != FUNC_NEG && rd_m == '0)) begin
      cls.early  = 1'b1;
      cls.status = ST_ZERO_DEN;
    end else if (func_i == FUNC_DIV && rn_m == '0) begin
      cls.early  = 1'b1;
      cls.status = ST_DIV_ZERO;
    end
  end

  assign in_ready_o = ~vld_q[wr_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = vld_q[rd_ptr_q];
  assign pop        = q_valid_o & q_ready_i;
  assign q_item_o   = ent_q[rd_ptr_q];

  always_comb begin
    vld_d = vld_q;
    if (push) vld_d[wr_ptr_q] = 1'b1;
    if (pop)  vld_d[rd_ptr_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= cls;
  end

endmodule

### src/rau_gcd.sv
// Euclidean reduction unit: divides a fraction by the GCD of its parts.
// One remainder bit per cycle for a%b, then exact quotients. Depends on rau_pkg.
module rau_gcd (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rau_pkg::MagWidth-1:0] mag_i,
  input  logic [rau_pkg::MagWidth-1:0] den_i,
  output logic                         done_o,
  output logic [rau_pkg::MagWidth-1:0] mag_o,
  output logic [rau_pkg::MagWidth-1:0] den_o
);
  import rau_pkg::*;

  gcd_state_e            st_q, st_d;
  gcd_phase_e            phase_q;
  logic [MagWidth-1:0]   b_q, rem_q, quo_q, dvd_q, mag_q, den_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [MagWidth:0]     trial;
  logic [MagWidth-1:0]   rem_sh, rem_nx, quo_nx;
  logic                  last;

  assign rem_sh = {rem_q[MagWidth-2:0], dvd_q[MagWidth-1]};
  assign trial  = {rem_q, dvd_q[MagWidth-1]} - {1'b0, b_q};
  assign rem_nx = trial[MagWidth] ? rem_sh : trial[MagWidth-1:0];
  assign quo_nx = {quo_q[MagWidth-2:0], ~trial[MagWidth]};
  assign last   = (cnt_q == '1);
  assign done_o = (st_q == G_DONE);
  assign mag_o  = mag_q;
  assign den_o  = den_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      G_IDLE:  if (start_i) st_d = (den_i == '0 || mag_i == '0) ? G_DONE : G_MOD;
      G_MOD:   if (last && phase_q == PH_DEN) st_d = G_DONE;
      G_DONE:  st_d = G_IDLE;
      default: st_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= G_IDLE;
      cnt_q   <= '0;
      phase_q <= PH_EUCLID;
    end else begin
      st_q <= st_d;
      case (st_q)
        G_IDLE: begin
          cnt_q   <= '0;
          phase_q <= PH_EUCLID;
        end
        G_MOD: begin
          cnt_q <= cnt_q + 1'b1;
          if (last) begin
            case (phase_q)
              PH_EUCLID: if (rem_nx == '0) phase_q <= PH_MAG;
              PH_MAG:    phase_q <= PH_DEN;
              default:   ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // b_q holds the divisor; dvd_q/rem_q run the shift-subtract divide
  always_ff @(posedge clk_i) begin
    case (st_q)
      G_IDLE: begin
        if (start_i) begin
          b_q   <= den_i;
          dvd_q <= mag_i;
          rem_q <= '0;
          mag_q <= mag_i;
          den_q <= (mag_i == '0) ? MagWidth'(1) : den_i;
        end
      end
      G_MOD: begin
        quo_q <= quo_nx;
        if (!last) begin
          dvd_q <= {dvd_q[MagWidth-2:0], 1'b0};
          rem_q <= rem_nx;
        end else begin
          rem_q <= '0;
          case (phase_q)
            PH_EUCLID: begin
              if (rem_nx == '0) begin
                dvd_q <= mag_q;
              end else begin
                b_q   <= rem_nx;
                dvd_q <= b_q;
              end
            end
            PH_MAG: begin
              mag_q <= quo_nx;
              dvd_q <= den_q;
            end
            default: den_q <= quo_nx;
          endcase
        end
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_IMP(a_gcd_nz, clk_i, rst_ni, st_q == G_MOD, b_q != '0)
  `ASSERT_NEXT(a_gcd_done, clk_i, rst_ni, st_q == G_DONE, st_q == G_IDLE)
  `ASSERT_IMP(a_gcd_cnt, clk_i, rst_ni, st_q != G_MOD, cnt_q == '0)

endmodule

### src/rau_back.sv
// Back end: reduce operands, combine with staged 32x32 products, reduce, check range.
// Equality tests only compare the reduced operands. Depends on rau_pkg and rau_gcd.
module rau_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  output logic                    q_ready_o,
  input  rau_pkg::item_t          q_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rau_pkg::res_t           out_res_o
);
  import rau_pkg::*;

  state_e                st_q, st_d;
  item_t                 it_q;
  logic [MagWidth-1:0]   am_q, ad_q, bm_q, bd_q, p1_q, p2_q, p3_q, rm_q, rd_q;
  logic                  rn_q;
  res_t                  res_q, res_d;
  logic                  ov_q;
  logic                  g_start;
  logic [MagWidth-1:0]   g_mag, g_den, g_mo, g_do;
  logic                  g_done;
  logic                  bneg;
  logic [MagWidth-1:0]   half;
  logic                  started_q;

  rau_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(g_start),
    .mag_i  (g_mag),
    .den_i  (g_den),
    .done_o (g_done),
    .mag_o  (g_mo),
    .den_o  (g_do)
  );

  assign half        = 64'd1 << (ValueWidth - 1);
  assign q_ready_o   = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;
  assign bneg        = (it_q.func == FUNC_SUB) ? ~it_q.b_neg : it_q.b_neg;

  always_comb begin
    g_start = 1'b0;
    g_mag   = '0;
    g_den   = '0;
    case (st_q)
      S_RED_A: begin
        g_mag = {{(MagWidth-ValueWidth){1'b0}}, it_q.a_mag};
        g_den = {{(MagWidth-ValueWidth){1'b0}}, it_q.a_den};
      end
      S_RED_B: begin
        g_mag = {{(MagWidth-ValueWidth){1'b0}}, it_q.b_mag};
        g_den = {{(MagWidth-ValueWidth){1'b0}}, it_q.b_den};
      end
      S_RED_R: begin g_mag = rm_q; g_den = rd_q; end
      default: ;
    endcase
    if ((st_q == S_RED_A || st_q == S_RED_B || st_q == S_RED_R) && !started_q) g_start = 1'b1;
  end

  always_comb begin
    st_d  = st_q;
    res_d = '0;
    case (st_q)
      S_IDLE:  if (q_valid_i) st_d = q_item_i.early ? S_OUT : S_RED_A;
      S_RED_A: if (g_done) st_d = (it_q.func == FUNC_NEG) ? S_COMB : S_RED_B;
      S_RED_B: if (g_done) st_d = (it_q.func == FUNC_EQ) ? S_OUT : S_MUL1;
      S_MUL1:  st_d = S_MUL2;
      S_MUL2:  st_d = S_COMB;
      S_COMB:  st_d = S_RED_R;
      S_RED_R: if (g_done) st_d = S_OUT;
      S_OUT:   if (!ov_q) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    if (it_q.early) begin
      res_d.status = it_q.status;
    end else if (it_q.func == FUNC_EQ) begin
      res_d.is_equal = (it_q.a_neg == it_q.b_neg || am_q == '0) &&
                       am_q == bm_q && ad_q == bd_q;
    end else if (rd_q > half - 1 || rm_q > (rn_q ? half : half - 1)) begin
      res_d.status = ST_OVERFLOW;
    end else begin
      res_d.result_numerator   = rn_q ? (32'd0 - rm_q[31:0]) : rm_q[31:0];
      res_d.result_denominator = rd_q[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      ov_q      <= 1'b0;
      started_q <= 1'b0;
    end else begin
      st_q <= st_d;
      started_q <= g_start ? 1'b1 : (g_done ? 1'b0 : started_q);
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (st_q == S_OUT && !ov_q) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) it_q <= q_item_i;
    if (st_q == S_RED_A && g_done) begin am_q <= g_mo; ad_q <= g_do; end
    if (st_q == S_RED_B && g_done) begin bm_q <= g_mo; bd_q <= g_do; end
    if (st_q == S_MUL1) begin
      p1_q <= am_q[31:0] * ((it_q.func == FUNC_ADD || it_q.func == FUNC_SUB ||
                             it_q.func == FUNC_DIV) ? bd_q[31:0] : bm_q[31:0]);
      p2_q <= ad_q[31:0] * ((it_q.func == FUNC_DIV) ? bm_q[31:0] : bd_q[31:0]);
    end
    if (st_q == S_MUL2) p3_q <= bm_q[31:0] * ad_q[31:0];
    if (st_q == S_COMB) begin
      case (it_q.func)
        FUNC_ADD, FUNC_SUB: begin
          rd_q <= p2_q;
          if (it_q.a_neg == bneg) begin rm_q <= p1_q + p3_q; rn_q <= it_q.a_neg; end
          else if (p1_q >= p3_q) begin rm_q <= p1_q - p3_q; rn_q <= it_q.a_neg; end
          else begin rm_q <= p3_q - p1_q; rn_q <= bneg; end
        end
        FUNC_NEG: begin rm_q <= am_q; rd_q <= ad_q; rn_q <= ~it_q.a_neg; end
        default:  begin rm_q <= p1_q; rd_q <= p2_q; rn_q <= it_q.a_neg ^ it_q.b_neg; end
      endcase
    end
    if (st_q == S_RED_R && g_done) begin
      rm_q <= g_mo;
      rd_q <= g_do;
      if (g_mo == '0) rn_q <= 1'b0;
    end
    if (st_q == S_OUT && !ov_q) res_q <= res_d;
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_back_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q && $stable(res_q))
  `ASSERT_NEXT(a_back_out, clk_i, rst_ni, st_q == S_OUT && !ov_q, ov_q)
  `ASSERT_IMP(a_back_rdy, clk_i, rst_ni, q_ready_o, st_q == S_IDLE)

endmodule

### src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: front end, queue and back end.
// Depends on rau_pkg, rau_if, rau_front, rau_gcd, rau_back.
//
//  channel   dir  payload
//  in_ch     in   func, four 32-bit operand parts
//  out_ch    out  result_numerator, result_denominator, is_equal, status
//
// A transaction flagged by the front end skips the reductions; otherwise up to three
// Euclid reductions set the time, each a run of bit-serial Euclid steps followed by
// two exact quotients.
// The front end queues two transactions while the back end works.
// Reset clears the queue and the state machines. Output holds until taken.
module rational_arithmetic_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  rau_in_if.sink   in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;
  res_t  res;

  rau_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_ch.valid),
    .in_ready_o(in_ch.ready),
    .func_i    (in_ch.func),
    .ln_i      (in_ch.left_numerator),
    .ld_i      (in_ch.left_denominator),
    .rn_i      (in_ch.right_numerator),
    .rd_i      (in_ch.right_denominator),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  rau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_item_i   (q_item),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_res_o  (res)
  );

  assign out_ch.result_numerator   = res.result_numerator;
  assign out_ch.result_denominator = res.result_denominator;
  assign out_ch.is_equal           = res.is_equal;
  assign out_ch.status             = res.status;

endmodule

### bench/tb_rational_arithmetic_unit.sv
// Testbench for the rational arithmetic unit: drives fraction pairs with random
// idling, predicts reduced results and compares each output transaction.
// Depends on rau_pkg, rau_if and the RTL of rational_arithmetic_unit.
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    logic        eq;
    logic [1:0]  st;
  } rat_res_t;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] ln, ld, rn, rd;
  } rat_op_t;

  typedef struct {
    bit              neg;
    longint unsigned mag;
    longint unsigned den;
  } frac_t;

  function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_t lowest_terms(frac_t f);
    longint unsigned g;
    g = euclid(f.mag, f.den);
    if (g == 0) g = 1;
    f.mag = f.mag / g;
    f.den = f.den / g;
    if (f.mag == 0) begin
      f.neg = 0;
      f.den = 1;
    end
    return f;
  endfunction

  function automatic frac_t to_frac(logic [31:0] n, logic [31:0] d);
    frac_t f;
    f.neg = n[31] ^ d[31];
    f.mag = n[31] ? (64'd1 << 32) - n : n;
    f.den = d[31] ? (64'd1 << 32) - d : d;
    return f;
  endfunction

  function automatic rat_res_t fault(status_e s);
    rat_res_t r;
    r.num = '0;
    r.den = '0;
    r.eq  = 1'b0;
    r.st  = s;
    return r;
  endfunction

  function automatic rat_res_t rational_result(rat_op_t op);
    frac_t a, b, r;
    rat_res_t o;
    bit nb;
    longint unsigned half, x, y;
    half = 64'd1 << 31;
    a = to_frac(op.ln, op.ld);
    b = to_frac(op.rn, op.rd);
    if (op.func > FUNC_EQ) return fault(ST_OK);
    if (a.den == 0 || (op.func != FUNC_NEG && b.den == 0)) return fault(ST_ZERO_DEN);
    a = lowest_terms(a);
    if (op.func != FUNC_NEG) b = lowest_terms(b);
    case (op.func)
      FUNC_ADD, FUNC_SUB: begin
        nb = (op.func == FUNC_SUB) ? !b.neg : b.neg;
        x = a.mag * b.den;
        y = b.mag * a.den;
        if (a.neg == nb) begin
          r.mag = x + y;
          r.neg = a.neg;
        end else if (x >= y) begin
          r.mag = x - y;
          r.neg = a.neg;
        end else begin
          r.mag = y - x;
          r.neg = nb;
        end
        r.den = a.den * b.den;
      end
      FUNC_MUL: begin
        r.neg = a.neg ^ b.neg;
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
      end
      FUNC_DIV: begin
        if (b.mag == 0) return fault(ST_DIV_ZERO);
        r.neg = a.neg ^ b.neg;
        r.mag = a.mag * b.den;
        r.den = a.den * b.mag;
      end
      FUNC_NEG: begin
        r.neg = !a.neg;
        r.mag = a.mag;
        r.den = a.den;
      end
      default: begin
        o = fault(ST_OK);
        o.eq = (a.neg == b.neg) && (a.mag == b.mag) && (a.den == b.den);
        return o;
      end
    endcase
    r = lowest_terms(r);
    if (r.den > half - 1 || r.mag > (r.neg ? half : half - 1)) return fault(ST_OVERFLOW);
    o.num = r.neg ? 32'(-r.mag) : 32'(r.mag);
    o.den = 31'(r.den);
    o.eq  = 1'b0;
    o.st  = ST_OK;
    return o;
  endfunction

  class rational_scoreboard;
    rat_res_t pending[$];
    int       errors;

    function void note_input(rat_op_t op);
      pending.push_back(rational_result(op));
    endfunction

    function void check_result(rat_res_t got);
      rat_res_t w;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.num !== w.num) begin
        $error("result_numerator expected %0d got %0d", $signed(w.num), $signed(got.num));
        errors++;
      end
      if (got.den !== w.den) begin
        $error("result_denominator expected %0d got %0d", w.den, got.den);
        errors++;
      end
      if (got.eq !== w.eq) begin
        $error("is_equal expected %0d got %0d", w.eq, got.eq);
        errors++;
      end
      if (got.st !== w.st) begin
        $error("status expected %0d got %0d", w.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  rational_scoreboard board = new();
  rat_op_t directed[$];
  bit      calm;
  bit      hold_off;
  bit      sent_all;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 4)) - 2);
      3, 4, 5: return 32'(int'($urandom_range(0, 200)) - 100);
      6: return 32'(int'($urandom_range(0, 60000)) - 30000);
      default: return $urandom;
    endcase
  endfunction

  function automatic rat_op_t random_op();
    rat_op_t op;
    op.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
    op.ln = pick_value();
    op.ld = pick_value();
    op.rn = pick_value();
    op.rd = pick_value();
    if (op.func == FUNC_EQ && $urandom_range(0, 1)) begin
      op.rn = op.ln * 3;
      op.rd = op.ld * 3;
    end
    return op;
  endfunction

  function automatic rat_op_t mk(logic [2:0] f, int ln, int ld, int rn, int rd);
    rat_op_t op;
    op.func = f;
    op.ln = ln;
    op.ld = ld;
    op.rn = rn;
    op.rd = rd;
    return op;
  endfunction

  task automatic send_op(rat_op_t op);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid             <= 1'b1;
    in_ch.func              <= op.func;
    in_ch.left_numerator    <= op.ln;
    in_ch.left_denominator  <= op.ld;
    in_ch.right_numerator   <= op.rn;
    in_ch.right_denominator <= op.rd;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(op);
  endtask

  initial begin
    in_ch.valid             = 1'b0;
    in_ch.func              = FUNC_ADD;
    in_ch.left_numerator    = '0;
    in_ch.left_denominator  = '0;
    in_ch.right_numerator   = '0;
    in_ch.right_denominator = '0;
    calm = 1'b0;
    sent_all = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed.push_back(mk(FUNC_ADD, 1, 2, 1, 3));
    directed.push_back(mk(FUNC_SUB, 1, 2, 1, 2));
    directed.push_back(mk(FUNC_MUL, -2, 4, 3, -9));
    directed.push_back(mk(FUNC_DIV, 3, 4, -6, 8));
    directed.push_back(mk(FUNC_NEG, 5, -10, 0, 0));
    directed.push_back(mk(FUNC_NEG, 32'h8000_0000, 1, 0, 0));
    directed.push_back(mk(FUNC_NEG, 32'h8000_0000, -1, 7, 7));
    directed.push_back(mk(FUNC_EQ, 2, 4, -3, -6));
    directed.push_back(mk(FUNC_EQ, 2, 4, 3, 6));
    directed.push_back(mk(FUNC_EQ, 1, 0, 1, 1));
    directed.push_back(mk(FUNC_ADD, 1, 1, 1, 0));
    directed.push_back(mk(FUNC_NEG, 1, 0, 1, 1));
    directed.push_back(mk(FUNC_DIV, 1, 2, 0, 5));
    directed.push_back(mk(FUNC_MUL, 0, -7, 5, 3));
    directed.push_back(mk(FUNC_ADD, 32'h7fff_ffff, 1, 1, 1));
    directed.push_back(mk(FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
    directed.push_back(mk(FUNC_DIV, 1, 32'h7fff_ffff, 32'h7fff_fffe, 1));
    directed.push_back(mk(FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000));
    directed.push_back(mk(FUNC_ADD, -1, -1, -1, -1));
    directed.push_back(mk(3'd6, 1, 1, 1, 1));
    directed.push_back(mk(3'd7, 0, 0, 0, 0));
    directed.push_back(mk(FUNC_EQ, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
                          32'h8000_0000));
    directed.push_back(mk(FUNC_EQ, 0, 1, 0, -1));
    foreach (directed[i]) send_op(directed[i]);
    for (int n = 0; n < 650; n++) begin
      calm = (n >= 300 && n < 400);
      send_op(random_op());
    end
    in_ch.valid <= 1'b0;
    sent_all = 1'b1;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_off = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_off && board.pending.size() >= 3) begin
        hold_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (40000) @(posedge clk_i);
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.result_numerator, out_ch.result_denominator,
                           out_ch.is_equal, out_ch.status});
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    while (!(sent_all && board.pending.size() == 0)) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 200000);
    $display("TEST FAILED");
    $finish;
  end
endmodule
